>>> rtl/ssl_pkg.sv
// ssl_pkg: shared types, constants and the arctangent table of the steering law core
// used by every module under rtl/, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ssl_pkg;

    // field widths
    localparam int POS_W      = 24;
    localparam int HEAD_W     = 15;
    localparam int SPEED_W    = 24;
    localparam int GAIN_W     = 16;
    localparam int YAW_W      = 16;
    localparam int S_TDATA_W  = 200;
    localparam int M_TDATA_W  = 16;

    // shared multiplier operand width and product width
    localparam int MUL_W      = 25;
    localparam int PROD_W     = 2 * MUL_W;

    // cordic operand widths
    localparam int NUM_W      = 63;
    localparam int DEN_W      = 32;
    localparam int ANG_W      = 25;

    // apb register map
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;
    localparam logic [1:0] REG_STEER_GAIN  = 2'd0;
    localparam logic [1:0] REG_STOP_SPEED  = 2'd1;
    localparam logic [1:0] REG_FLOOR_SPEED = 2'd2;

    localparam logic [GAIN_W-1:0]  STEER_GAIN_RST  = 16'd256;
    localparam logic [SPEED_W-1:0] STOP_SPEED_RST  = 24'd7;
    localparam logic [SPEED_W-1:0] FLOOR_SPEED_RST = 24'd66;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_IDX_W       = 5;

    typedef struct packed {
        logic [GAIN_W-1:0]  steer_gain;
        logic [SPEED_W-1:0] stop_speed;
        logic [SPEED_W-1:0] floor_speed;
    } cfg_t;

    // atan(2^-i) in q.24 radians
    function automatic logic [23:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ssl_apb_regs.sv
// ssl_apb_regs: apb configuration registers of the steering law core
// depends on ssl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssl_apb_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ssl_pkg::APB_AW-1:0]    paddr,
    input  wire logic [ssl_pkg::APB_DW-1:0]    pwdata,
    output logic      [ssl_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    output ssl_pkg::cfg_t                      cfg
);

    ssl_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.steer_gain  <= ssl_pkg::STEER_GAIN_RST;
            cfg_reg.stop_speed  <= ssl_pkg::STOP_SPEED_RST;
            cfg_reg.floor_speed <= ssl_pkg::FLOOR_SPEED_RST;
        end else if (wr_en) begin
            case (idx)
                ssl_pkg::REG_STEER_GAIN:  cfg_reg.steer_gain  <= pwdata[ssl_pkg::GAIN_W-1:0];
                ssl_pkg::REG_STOP_SPEED:  cfg_reg.stop_speed  <= pwdata[ssl_pkg::SPEED_W-1:0];
                ssl_pkg::REG_FLOOR_SPEED: cfg_reg.floor_speed <= pwdata[ssl_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            ssl_pkg::REG_STEER_GAIN:  prdata = {16'd0, cfg_reg.steer_gain};
            ssl_pkg::REG_STOP_SPEED:  prdata = {8'd0, cfg_reg.stop_speed};
            ssl_pkg::REG_FLOOR_SPEED: prdata = {8'd0, cfg_reg.floor_speed};
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/ssl_mul.sv
// ssl_mul: shared signed 25x25 multiplier with registered product
// depends on ssl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssl_mul (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic signed [ssl_pkg::MUL_W-1:0]   a,
    input  wire logic signed [ssl_pkg::MUL_W-1:0]   b,
    output logic signed      [ssl_pkg::PROD_W-1:0]  p
);

    logic signed [ssl_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> rtl/ssl_cordic.sv
// ssl_cordic: iterative atan2 for nonnegative operands, result in q.24 radians
// normalizes the operand pair, then runs one vectoring step per cycle; depends on ssl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssl_cordic #(
    parameter int CORDIC_STEPS = ssl_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [ssl_pkg::NUM_W-1:0]    num,
    input  wire logic [ssl_pkg::DEN_W-1:0]    den,
    output logic                              done,
    output logic      [ssl_pkg::ANG_W-1:0]    angle
);

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam int XW = 34;
    localparam int ZW = 27;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_RSH  = 4'b0010,
        C_LSH  = 4'b0100,
        C_ITER = 4'b1000
    } cst_t;

    cst_t state_reg, state_next;
    logic done_reg, done_next;

    logic [ssl_pkg::NUM_W-1:0] ny_reg, ny_next;
    logic [ssl_pkg::DEN_W-1:0] nx_reg, nx_next;
    logic signed [XW-1:0]      x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]      z_reg, z_next;
    logic [IW-1:0]             i_reg, i_next;
    logic [ssl_pkg::ANG_W-1:0] ang_reg, ang_next;

    logic signed [XW-1:0]      dx, dy;
    logic signed [ZW-1:0]      step_ang;
    logic signed [XW-1:0]      x_it, y_it;
    logic signed [ZW-1:0]      z_it;

    assign dx       = y_reg >>> i_reg;
    assign dy       = x_reg >>> i_reg;
    assign step_ang = ZW'({3'b000,
                           ssl_pkg::atan_lut(ssl_pkg::ATAN_IDX_W'(i_reg))});

    always_comb begin
        if (y_reg > 0) begin
            x_it = x_reg + dx;
            y_it = y_reg - dy;
            z_it = z_reg + step_ang;
        end else begin
            x_it = x_reg - dx;
            y_it = y_reg + dy;
            z_it = z_reg - step_ang;
        end
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        ny_next    = ny_reg;
        nx_next    = nx_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        i_next     = i_reg;
        ang_next   = ang_reg;
        case (state_reg)
            C_IDLE: begin
                if (start) begin
                    ny_next    = num;
                    nx_next    = den;
                    state_next = C_RSH;
                end
            end
            C_RSH: begin
                // shrink both until they fit 30 bits, eight bits at a time while safe
                if (|ny_reg[62:38]) begin
                    ny_next = ny_reg >> 8;
                    nx_next = nx_reg >> 8;
                end else if ((|ny_reg[62:30]) || (|nx_reg[31:30])) begin
                    ny_next = ny_reg >> 1;
                    nx_next = nx_reg >> 1;
                end else if (ny_reg == '0) begin
                    ang_next   = '0;
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end else begin
                    state_next = C_LSH;
                end
            end
            C_LSH: begin
                // grow until the larger one reaches bit 29
                if ((ny_reg[29:21] == '0) && (nx_reg[29:21] == '0)) begin
                    ny_next = ny_reg << 8;
                    nx_next = nx_reg << 8;
                end else if (!ny_reg[29] && !nx_reg[29]) begin
                    ny_next = ny_reg << 1;
                    nx_next = nx_reg << 1;
                end else begin
                    x_next     = XW'({4'b0000, nx_reg[29:0]});
                    y_next     = XW'({4'b0000, ny_reg[29:0]});
                    z_next     = '0;
                    i_next     = '0;
                    state_next = C_ITER;
                end
            end
            C_ITER: begin
                x_next = x_it;
                y_next = y_it;
                z_next = z_it;
                if (i_reg == IW'(CORDIC_STEPS - 1)) begin
                    ang_next   = z_it[ZW-1] ? '0 : z_it[ssl_pkg::ANG_W-1:0];
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        ny_reg  <= ny_next;
        nx_reg  <= nx_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        i_reg   <= i_next;
        ang_reg <= ang_next;
    end

    assign done  = done_reg;
    assign angle = ang_reg;

endmodule

`default_nettype wire

>>> rtl/stanley_steering_law_core.sv
// stanley_steering_law_core: stanley lateral steering law, top level and sequencer
// depends on ssl_pkg, ssl_apb_regs, ssl_mul, ssl_cordic
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   bus                       what moves
// s_        in    tvalid/tready/tdata/tuser  one waypoint/pose/speed word
// m_        out   tvalid/tready/tdata/tuser  one yaw command word
// apb       in    psel/penable/pwrite/...    steer_gain, stop_speed, floor_speed
//
// a word below stop_speed is answered in the cycle after it is accepted, with the held heading error
// a moving word runs through the sequencer states, the cordic normalize (its length set by the
// operand magnitudes) and the CORDIC_STEPS vectoring steps; a zero numerator skips the steps
// s_tready is high only when the sequencer is idle and the output register is free
// or being emptied, so one word at a time; m_ stalls hold the result register
// synchronous reset clears the sequencer, m_tvalid and the held heading error, and loads the config defaults

module stanley_steering_law_core #(
    parameter int CORDIC_STEPS = ssl_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata, from bit 0: pos_x, pos_y, goal_x, goal_y, start_x, start_y,
    // heading_goal, heading_now, speed, zero pad
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ssl_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                              s_tuser,      // start_valid
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [ssl_pkg::M_TDATA_W-1:0]     m_tdata,      // steer_yaw
    output logic                                   m_tuser,      // held
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ssl_pkg::APB_AW-1:0]        paddr,
    input  wire logic [ssl_pkg::APB_DW-1:0]        pwdata,
    output logic      [ssl_pkg::APB_DW-1:0]        prdata,
    output logic                                   pready
);

    localparam int MW = ssl_pkg::MUL_W;
    localparam int PW = ssl_pkg::PROD_W;
    localparam int CW = PW + 1;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_MUL_A  = 13'b0000000000010,
        ST_MUL_B  = 13'b0000000000100,
        ST_CT     = 13'b0000000001000,
        ST_ABS    = 13'b0000000010000,
        ST_NRM    = 13'b0000000100000,
        ST_MUL_LO = 13'b0000001000000,
        ST_MUL_HI = 13'b0000010000000,
        ST_SUM    = 13'b0000100000000,
        ST_CST    = 13'b0001000000000,
        ST_CWT    = 13'b0010000000000,
        ST_RND    = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } st_t;

    st_t state_reg, state_next;

    ssl_pkg::cfg_t cfg;

    // input word fields
    logic signed [ssl_pkg::POS_W-1:0]  px, py, gx, gy, sx, sy, sx_eff, sy_eff;
    logic signed [ssl_pkg::HEAD_W-1:0] hg, hn;
    logic [ssl_pkg::SPEED_W-1:0]       spd, spd_max;
    logic                              s_acc, stopped;
    logic signed [ssl_pkg::YAW_W-1:0]  herr;

    // working registers
    logic signed [MW-1:0]              dx1_reg, dy2_reg, dy1_reg, dx2_reg;
    logic signed [ssl_pkg::YAW_W-1:0]  herr_reg, last_err_reg;
    logic [ssl_pkg::DEN_W-1:0]         den_reg;
    logic signed [CW-1:0]              ct_reg;
    logic                              neg_reg;
    logic [PW-1:0]                     mag_reg;
    logic [46:0]                       uy_reg;
    logic [ssl_pkg::DEN_W-1:0]         ux_reg;
    logic [ssl_pkg::NUM_W-1:0]         num_reg;
    logic [ssl_pkg::ANG_W-1:0]         cang_reg;
    logic signed [14:0]                ang_reg;

    // output register
    logic                              m_valid_reg;
    logic [ssl_pkg::YAW_W-1:0]         m_data_reg;
    logic                              m_user_reg;
    logic                              out_free;

    // shared multiplier
    logic                              mul_en;
    logic signed [MW-1:0]              mul_a, mul_b;
    logic signed [PW-1:0]              mul_p;

    // cordic
    logic                              c_start, c_done;
    logic [ssl_pkg::ANG_W-1:0]         c_angle;

    logic [1:0]                        sh;
    logic [25:0]                       rnd_sum;
    logic signed [14:0]                rnd_mag;
    logic signed [16:0]                cmd;
    logic signed [ssl_pkg::YAW_W-1:0]  cmd_sat;

    ssl_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssl_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    ssl_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (c_start),
        .num     (num_reg),
        .den     (ux_reg),
        .done    (c_done),
        .angle   (c_angle)
    );

    // unpack the input word
    assign px  = s_tdata[23:0];
    assign py  = s_tdata[47:24];
    assign gx  = s_tdata[71:48];
    assign gy  = s_tdata[95:72];
    assign sx  = s_tdata[119:96];
    assign sy  = s_tdata[143:120];
    assign hg  = s_tdata[158:144];
    assign hn  = s_tdata[173:159];
    assign spd = s_tdata[197:174];

    // without a previous waypoint the vehicle position stands in for it
    assign sx_eff  = s_tuser ? sx : px;
    assign sy_eff  = s_tuser ? sy : py;
    assign herr    = ssl_pkg::YAW_W'(hg) - ssl_pkg::YAW_W'(hn);
    assign spd_max = (spd > cfg.floor_speed) ? spd : cfg.floor_speed;
    assign stopped = spd < cfg.stop_speed;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;

    // multiplier operand select: two cross-product terms, then gain times |ct|
    always_comb begin
        mul_en = 1'b0;
        mul_a  = dx1_reg;
        mul_b  = dy2_reg;
        case (state_reg)
            ST_MUL_A: begin
                mul_en = 1'b1;
            end
            ST_MUL_B: begin
                mul_en = 1'b1;
                mul_a  = dy1_reg;
                mul_b  = dx2_reg;
            end
            ST_MUL_LO: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, uy_reg[23:0]};
                mul_b  = MW'({1'b0, cfg.steer_gain});
            end
            ST_MUL_HI: begin
                mul_en = 1'b1;
                mul_a  = {2'b00, uy_reg[46:24]};
                mul_b  = MW'({1'b0, cfg.steer_gain});
            end
            default: ;
        endcase
    end

    assign c_start = (state_reg == ST_CST);

    // pre-scale |ct| below 2^47, the speed term by the same amount
    assign sh = mag_reg[49] ? 2'd3 : mag_reg[48] ? 2'd2 : mag_reg[47] ? 2'd1 : 2'd0;

    // round the cordic angle to q3.12 and give it the sign of ct
    assign rnd_sum = {1'b0, cang_reg} + 26'd2048;
    assign rnd_mag = {1'b0, rnd_sum[25:12]};

    // final sum and saturation
    assign cmd     = 17'(herr_reg) + 17'(ang_reg);
    assign cmd_sat = (cmd > 17'sd32767)  ? 16'sd32767 :
                     (cmd < -17'sd32768) ? -16'sd32768 : cmd[15:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_acc && !stopped) state_next = ST_MUL_A;
            ST_MUL_A:  state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_CT;
            ST_CT:     state_next = ST_ABS;
            ST_ABS:    state_next = ST_NRM;
            ST_NRM:    state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_CST;
            ST_CST:    state_next = ST_CWT;
            ST_CWT:    if (c_done) state_next = ST_RND;
            ST_RND:    state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            last_err_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (s_acc && !stopped) begin
                last_err_reg <= herr;
            end
            if (s_acc && stopped) begin
                m_valid_reg <= 1'b1;
            end else if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            dx1_reg  <= MW'(gx) - MW'(px);
            dy2_reg  <= MW'(gy) - MW'(sy_eff);
            dy1_reg  <= MW'(gy) - MW'(py);
            dx2_reg  <= MW'(gx) - MW'(sx_eff);
            herr_reg <= herr;
            den_reg  <= {spd_max, 8'd0};
        end
        if (s_acc && stopped) begin
            // stopped: repeat the last heading error
            m_data_reg <= last_err_reg;
            m_user_reg <= 1'b1;
        end else if ((state_reg == ST_OUT) && out_free) begin
            m_data_reg <= cmd_sat;
            m_user_reg <= 1'b0;
        end
        case (state_reg)
            ST_MUL_B: ct_reg <= CW'(mul_p);
            ST_CT:    ct_reg <= ct_reg - CW'(mul_p);
            ST_ABS: begin
                neg_reg <= ct_reg[CW-1];
                mag_reg <= ct_reg[CW-1] ? PW'(-ct_reg) : ct_reg[PW-1:0];
            end
            ST_NRM: begin
                uy_reg <= 47'(mag_reg >> sh);
                ux_reg <= den_reg >> sh;
            end
            ST_MUL_HI: num_reg <= {23'd0, mul_p[39:0]};
            ST_SUM:    num_reg <= {mul_p[38:0], 24'd0} + num_reg;
            ST_CWT:    if (c_done) cang_reg <= c_angle;
            ST_RND:    ang_reg <= neg_reg ? -rnd_mag : rnd_mag;
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire
